// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the map builder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- rtl/wsmb_pkg.sv -----
// Shared field widths, request codes and controller/datapath interface types.
package wsmb_pkg;

   // Port field widths
   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 4;
   localparam int WEIGHT_W = 8;
   localparam int SLOT_W   = 12;
   localparam int SERVER_W = 4;
   localparam int TOTAL_W  = 12;
   localparam int USED_W   = 5;

   // Request codes
   localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REBUILD = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic table_wr;
      logic read_issue;
      logic count_start;
      logic count_step;
      logic decide;
      logic scan_start;
      logic scan_step;
      logic update;
      logic load_rsp;
   } wsmb_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic cnt_last;
      logic build_none;
      logic slot_last;
      logic rsp_busy;
   } wsmb_status_type;

endpackage

// ----- rtl/weighted_server_map_builder_unit.sv -----
// Top level of the weighted round robin server map builder.
//
// Request channel (req_*): one request per item, mode selects write entry,
// rebuild map or read slot; taken when req_valid is high and req_stall low.
// Response channel (rsp_*): exactly one response per request, in order,
// taken when rsp_valid is high and rsp_stall low.
// Configuration (csr_*): use_all_backup, always ready; write only while idle.
// Sequence: a write or read request passes through the done state, where its
// response is loaded into the output register, before the next one is taken.
// A rebuild makes one pass over the table to count, then for each slot of the
// new map a walk over all servers through the single score update unit plus an
// update step to charge the winner and write the slot map RAM.
// A finished response waits in an output register; a new request is still
// taken while it waits, and that request's response holds back until the
// register is free. Reset clears the server table, map length, server count
// and configuration; slot map contents are not cleared and are only read
// below the map length.
module weighted_server_map_builder_unit #(
   parameter int MAX_SERVERS = 16,
   parameter int MAP_DEPTH   = 4096,
   parameter int WEIGHT_MAX  = 255
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_use_all_backup,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [wsmb_pkg::MODE_W-1:0]     req_mode,
   input  logic [wsmb_pkg::INDEX_W-1:0]    req_server_index,
   input  logic                            req_server_running,
   input  logic                            req_server_backup,
   input  logic [wsmb_pkg::WEIGHT_W-1:0]   req_server_weight,
   input  logic [wsmb_pkg::SLOT_W-1:0]     req_slot_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [wsmb_pkg::SERVER_W-1:0]   rsp_slot_server,
   output logic                            rsp_slot_valid,
   output logic [wsmb_pkg::TOTAL_W-1:0]    rsp_total_weight,
   output logic [wsmb_pkg::USED_W-1:0]     rsp_servers_used
);
   import wsmb_pkg::*;

   wsmb_cmd_type    cmd;
   wsmb_status_type status;

   // Sequencer
   wsmb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Table, scores, map and response
   wsmb_datapath #(
      .MAX_SERVERS (MAX_SERVERS),
      .MAP_DEPTH   (MAP_DEPTH),
      .WEIGHT_MAX  (WEIGHT_MAX)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_valid          (csr_valid),
      .csr_use_all_backup (csr_use_all_backup),
      .csr_ready          (csr_ready),
      .req_server_index   (req_server_index),
      .req_server_running (req_server_running),
      .req_server_backup  (req_server_backup),
      .req_server_weight  (req_server_weight),
      .req_slot_index     (req_slot_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_slot_server    (rsp_slot_server),
      .rsp_slot_valid     (rsp_slot_valid),
      .rsp_total_weight   (rsp_total_weight),
      .rsp_servers_used   (rsp_servers_used)
   );

endmodule

// ----- rtl/wsmb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wsmb_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/wsmb_ctrl.sv -----
// Sequencer for table writes, slot reads and the map rebuild.
`include "assert_macros.svh"

module wsmb_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [wsmb_pkg::MODE_W-1:0]   req_mode,
   output logic                          req_stall,
   input  wsmb_pkg::wsmb_status_type     status,
   output wsmb_pkg::wsmb_cmd_type        cmd
);
   import wsmb_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_COUNT  = 6'b000010,
      ST_DECIDE = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_UPDATE = 6'b010000,
      ST_DONE   = 6'b100000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_mode)
                  MODE_WRITE: begin
                     cmd.table_wr = 1'b1;
                     state_in     = ST_DONE;
                  end
                  MODE_REBUILD: begin
                     cmd.count_start = 1'b1;
                     state_in        = ST_COUNT;
                  end
                  MODE_READ: begin
                     cmd.read_issue = 1'b1;
                     state_in       = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_COUNT: begin
            cmd.count_step = 1'b1;
            if (status.cnt_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (status.build_none) begin
               state_in = ST_DONE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.cnt_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.slot_last ? ST_DONE : ST_SCAN;
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Take a new request only between items
   assign req_stall = (state_ff != ST_IDLE);

   `ASSERT_IMPLY(a_load_free, clock, reset, cmd.load_rsp, !status.rsp_busy,
                 "response loaded over a stalled response")

endmodule

// ----- rtl/wsmb_datapath.sv -----
// Server table, score registers, slot map and response register.
`include "assert_macros.svh"

module wsmb_datapath #(
   parameter int MAX_SERVERS = 16,
   parameter int MAP_DEPTH   = 4096,
   parameter int WEIGHT_MAX  = 255
) (
   input  logic                            clock,
   input  logic                            reset,
   input  wsmb_pkg::wsmb_cmd_type          cmd,
   output wsmb_pkg::wsmb_status_type       status,
   input  logic                            csr_valid,
   input  logic                            csr_use_all_backup,
   output logic                            csr_ready,
   input  logic [wsmb_pkg::INDEX_W-1:0]    req_server_index,
   input  logic                            req_server_running,
   input  logic                            req_server_backup,
   input  logic [wsmb_pkg::WEIGHT_W-1:0]   req_server_weight,
   input  logic [wsmb_pkg::SLOT_W-1:0]     req_slot_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [wsmb_pkg::SERVER_W-1:0]   rsp_slot_server,
   output logic                            rsp_slot_valid,
   output logic [wsmb_pkg::TOTAL_W-1:0]    rsp_total_weight,
   output logic [wsmb_pkg::USED_W-1:0]     rsp_servers_used
);
   import wsmb_pkg::*;

   localparam int SRV_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_W = $clog2(MAX_SERVERS + 1);
   localparam int TOT_W = $clog2(MAX_SERVERS * WEIGHT_MAX + 1);
   localparam int SUM_W = TOT_W + 1;
   localparam int QW    = $clog2(MAX_SERVERS + 2);
   localparam int LEN_W = $clog2(MAP_DEPTH + 1);
   localparam int AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

   // Server table
   logic                run_ff [MAX_SERVERS];
   logic                bk_ff  [MAX_SERVERS];
   logic [WEIGHT_W-1:0] w_ff   [MAX_SERVERS];

   // Scores kept as bin and remainder of (score + total) / total
   logic [QW-1:0]       q_ff   [MAX_SERVERS];
   logic [TOT_W-1:0]    r_ff   [MAX_SERVERS];

   logic                use_all_ff;

   logic [SRV_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    act_n_ff, bck_n_ff;
   logic [TOT_W-1:0]    act_w_ff, bck_w_ff;
   logic [WEIGHT_W-1:0] first_bw_ff;
   logic [SRV_W-1:0]    first_idx_ff;

   logic [TOT_W-1:0]    total_ff;
   logic                want_ff;
   logic                single_ff;
   logic [LEN_W-1:0]    map_len_ff;
   logic [CNT_W-1:0]    used_ff;

   logic [LEN_W-1:0]    slot_ff;
   logic [SRV_W-1:0]    best_ff;
   logic [QW-1:0]       best_q_ff;
   logic                found_ff;

   logic                rd_ff;
   logic                slot_ok_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SERVER_W-1:0] rsp_server_ff;
   logic                rsp_slot_valid_ff;
   logic [TOTAL_W-1:0]  rsp_total_ff;
   logic [USED_W-1:0]   rsp_used_ff;

   logic [31:0]         idx32, slot32, len32, used32, rd32;
   logic                idx_ok;
   logic [SRV_W-1:0]    idx;
   logic [WEIGHT_W-1:0] wsat;

   logic                cur_run, cur_bk, elig;
   logic [WEIGHT_W-1:0] cur_w;
   logic [SUM_W-1:0]    sum;
   logic                ge;
   logic [QW-1:0]       q_new;
   logic [TOT_W-1:0]    r_new;

   logic                want_sel, single_sel;
   logic [TOT_W-1:0]    total_sel;
   logic [CNT_W-1:0]    used_sel;
   logic [LEN_W-1:0]    fill_sel;

   logic [SRV_W-1:0]    ram_rdata;

   // Request field decode
   assign idx32  = 32'(req_server_index);
   assign idx_ok = idx32 < MAX_SERVERS;
   assign idx    = idx32[SRV_W-1:0];
   assign wsat   = (32'(req_server_weight) > WEIGHT_MAX) ? WEIGHT_W'(WEIGHT_MAX)
                                                           : req_server_weight;
   assign slot32 = 32'(req_slot_index);
   assign len32  = 32'(map_len_ff);
   assign used32 = 32'(used_ff);
   assign rd32   = 32'(ram_rdata);

   // Configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         use_all_ff <= 1'b0;
      end else if (csr_valid) begin
         use_all_ff <= csr_use_all_backup;
      end
   end

   // Server table writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SERVERS; i++) begin
            run_ff[i] <= 1'b0;
            bk_ff[i]  <= 1'b0;
            w_ff[i]   <= '0;
         end
      end else if (cmd.table_wr && idx_ok) begin
         run_ff[idx] <= req_server_running;
         bk_ff[idx]  <= req_server_backup;
         w_ff[idx]   <= wsat;
      end
   end

   // Current server under the walk
   assign cur_run = run_ff[cnt_ff];
   assign cur_bk  = bk_ff[cnt_ff];
   assign cur_w   = w_ff[cnt_ff];
   assign elig    = cur_run && (cur_bk == want_ff) && (!single_ff || cnt_ff == first_idx_ff);

   // Score step: add weight, carry into the next bin past the total
   assign sum   = SUM_W'(32'(r_ff[cnt_ff]) + 32'(cur_w));
   assign ge    = sum >= {1'b0, total_ff};
   assign r_new = ge ? TOT_W'(sum - {1'b0, total_ff}) : TOT_W'(sum);
   assign q_new = ge ? QW'(q_ff[cnt_ff] + 1'b1) : q_ff[cnt_ff];

   // Server walk counter
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.count_start || cmd.scan_start) begin
         cnt_in = '0;
      end else if (cmd.count_step || cmd.scan_step) begin
         cnt_in = status.cnt_last ? '0 : SRV_W'(cnt_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Count eligible servers and weights
   always_ff @(posedge clock) begin
      if (cmd.count_start) begin
         act_n_ff     <= '0;
         bck_n_ff     <= '0;
         act_w_ff     <= '0;
         bck_w_ff     <= '0;
         first_bw_ff  <= '0;
         first_idx_ff <= '0;
      end else if (cmd.count_step && cur_run) begin
         if (cur_bk) begin
            bck_n_ff <= CNT_W'(bck_n_ff + 1'b1);
            bck_w_ff <= TOT_W'(32'(bck_w_ff) + 32'(cur_w));
            if (bck_n_ff == '0) begin
               first_bw_ff  <= cur_w;
               first_idx_ff <= cnt_ff;
            end
         end else begin
            act_n_ff <= CNT_W'(act_n_ff + 1'b1);
            act_w_ff <= TOT_W'(32'(act_w_ff) + 32'(cur_w));
         end
      end
   end

   // Pick the server set: active first, then all backups or the first one
   always_comb begin
      want_sel   = 1'b0;
      single_sel = 1'b0;
      total_sel  = '0;
      used_sel   = '0;
      if (act_n_ff != '0) begin
         total_sel = act_w_ff;
         used_sel  = act_n_ff;
      end else if (bck_n_ff != '0) begin
         want_sel = 1'b1;
         if (use_all_ff) begin
            total_sel = bck_w_ff;
            used_sel  = bck_n_ff;
         end else begin
            single_sel = 1'b1;
            total_sel  = TOT_W'(first_bw_ff);
            used_sel   = CNT_W'(1);
         end
      end
      fill_sel = (32'(total_sel) > MAP_DEPTH) ? LEN_W'(MAP_DEPTH) : LEN_W'(total_sel);
   end

   // Latch the map shape
   always_ff @(posedge clock) begin
      if (reset) begin
         map_len_ff <= '0;
         used_ff    <= '0;
         total_ff   <= '0;
         want_ff    <= 1'b0;
         single_ff  <= 1'b0;
      end else if (cmd.decide) begin
         map_len_ff <= fill_sel;
         used_ff    <= used_sel;
         total_ff   <= total_sel;
         want_ff    <= want_sel;
         single_ff  <= single_sel;
      end
   end

   // Score registers: clear during count, step during scan, pay back the winner
   always_ff @(posedge clock) begin
      if (cmd.count_step) begin
         q_ff[cnt_ff] <= QW'(1);
         r_ff[cnt_ff] <= '0;
      end else if (cmd.scan_step && elig) begin
         q_ff[cnt_ff] <= q_new;
         r_ff[cnt_ff] <= r_new;
      end else if (cmd.update) begin
         q_ff[best_ff] <= QW'(best_q_ff - 1'b1);
      end
   end

   // Track the first server in the highest bin
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff  <= 1'b0;
         best_ff   <= '0;
         best_q_ff <= '0;
         slot_ff   <= '0;
      end else begin
         if (cmd.scan_start || cmd.update) begin
            found_ff <= 1'b0;
         end else if (cmd.scan_step && elig && (!found_ff || q_new > best_q_ff)) begin
            found_ff  <= 1'b1;
            best_ff   <= cnt_ff;
            best_q_ff <= q_new;
         end
         if (cmd.scan_start) begin
            slot_ff <= '0;
         end else if (cmd.update) begin
            slot_ff <= LEN_W'(slot_ff + 1'b1);
         end
      end
   end

   // Slot map
   wsmb_ram #(
      .WIDTH (SRV_W),
      .DEPTH (MAP_DEPTH)
   ) u_slot_map (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (slot_ff[AW-1:0]),
      .wr_data (best_ff),
      .rd_en   (cmd.read_issue),
      .rd_addr (slot32[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // Capture read request kind and range check
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff      <= 1'b0;
         slot_ok_ff <= 1'b0;
      end else if (cmd.accept) begin
         rd_ff      <= cmd.read_issue;
         slot_ok_ff <= slot32 < len32;
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_slot_valid_ff <= rd_ff && slot_ok_ff;
         rsp_server_ff     <= (rd_ff && slot_ok_ff) ? rd32[SERVER_W-1:0] : '0;
         rsp_total_ff      <= len32[TOTAL_W-1:0];
         rsp_used_ff       <= used32[USED_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_server  = rsp_server_ff;
   assign rsp_slot_valid   = rsp_slot_valid_ff;
   assign rsp_total_weight = rsp_total_ff;
   assign rsp_servers_used = rsp_used_ff;

   // Status to controller
   assign status.cnt_last   = (cnt_ff == SRV_W'(MAX_SERVERS - 1));
   assign status.build_none = (total_sel == '0);
   assign status.slot_last  = (LEN_W'(slot_ff + 1'b1) == map_len_ff);
   assign status.rsp_busy   = rsp_valid_ff && rsp_stall;

   `ASSERT_IMPLY(a_slot_won, clock, reset, cmd.update, found_ff,
                 "slot filled with no eligible server")
   `ASSERT_IMPLY(a_bin_floor, clock, reset, cmd.update, best_q_ff != '0,
                 "winner score bin underflow")
   `ASSERT_IMPLY(a_slot_range, clock, reset, cmd.update, 32'(slot_ff) < len32,
                 "slot map write past map length")
   `ASSERT_NEXT(a_len_bound, clock, reset, cmd.decide, len32 <= MAP_DEPTH,
                "map length above map depth")

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the weighted round robin server map builder.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import wsmb_pkg::*;

   localparam int SERVERS         = 16;
   localparam int MAP_SLOTS       = 4096;
   localparam int ITEMS_PER_PHASE = 330;
   localparam int WEIGHT_BUDGET   = 240;
   localparam int HOLD_CYCLES     = 400;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [INDEX_W-1:0]  server_index;
      logic                server_running;
      logic                server_backup;
      logic [WEIGHT_W-1:0] server_weight;
      logic [SLOT_W-1:0]   slot_index;
   } map_request_type;

   typedef struct packed {
      logic [SERVER_W-1:0] slot_server;
      logic                slot_valid;
      logic [TOTAL_W-1:0]  total_weight;
      logic [USED_W-1:0]   servers_used;
   } map_answer_type;

   typedef struct {
      bit              is_csr;
      bit              csr_value;
      map_request_type req;
      bit              fixed;
      map_answer_type  want;
   } probe_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_use_all_backup = 1'b0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [MODE_W-1:0]   req_mode = '0;
   logic [INDEX_W-1:0]  req_server_index = '0;
   logic                req_server_running = 1'b0;
   logic                req_server_backup = 1'b0;
   logic [WEIGHT_W-1:0] req_server_weight = '0;
   logic [SLOT_W-1:0]   req_slot_index = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SERVER_W-1:0] rsp_slot_server;
   logic                rsp_slot_valid;
   logic [TOTAL_W-1:0]  rsp_total_weight;
   logic [USED_W-1:0]   rsp_servers_used;

   // Shadow copy of the server table, slot map and setting
   bit                  all_backup;
   bit                  run_tbl [SERVERS];
   bit                  bck_tbl [SERVERS];
   bit [WEIGHT_W-1:0]   wgt_tbl [SERVERS];
   int                  score_tbl [SERVERS];
   bit [SERVER_W-1:0]   slot_tbl [MAP_SLOTS];
   int                  map_len;
   int                  used_n;

   map_answer_type      pending_answers [$];
   int                  error_count = 0;
   int                  served = 0;
   int                  send_gap_pct = 0;
   int                  stall_pct = 0;
   int                  hold_left = 0;
   int                  gap_pct_by_phase [3] = '{8, 63, 0};
   int                  stall_pct_by_phase [3] = '{63, 8, 0};

   // Directed requests; a fixed row carries its answer, the rest use the shadow model
   probe_row_type probe_tbl [25] = '{
      // empty table after reset, unused mode with every field at its maximum
      '{0, 0, '{MODE_READ,    4'd0,  1'b0, 1'b0, 8'd0,   12'd0},    1, '{4'd0,  1'b0, 12'd0,   5'd0}},
      '{0, 0, '{MODE_REBUILD, 4'd0,  1'b0, 1'b0, 8'd0,   12'd0},    1, '{4'd0,  1'b0, 12'd0,   5'd0}},
      '{0, 0, '{MODE_UNUSED,  4'd15, 1'b1, 1'b1, 8'd255, 12'd4095}, 1, '{4'd0,  1'b0, 12'd0,   5'd0}},
      // single server at full weight
      '{0, 0, '{MODE_WRITE,   4'd15, 1'b1, 1'b0, 8'd255, 12'd0},    1, '{4'd0,  1'b0, 12'd0,   5'd0}},
      '{0, 0, '{MODE_REBUILD, 4'd0,  1'b0, 1'b0, 8'd0,   12'd0},    1, '{4'd0,  1'b0, 12'd255, 5'd1}},
      '{0, 0, '{MODE_READ,    4'd0,  1'b0, 1'b0, 8'd0,   12'd254},  1, '{4'd15, 1'b1, 12'd255, 5'd1}},
      '{0, 0, '{MODE_READ,    4'd0,  1'b0, 1'b0, 8'd0,   12'd255},  1, '{4'd0,  1'b0, 12'd255, 5'd1}},
      // two servers, both weights zero
      '{0, 0, '{MODE_WRITE,   4'd0,  1'b1, 1'b0, 8'd0,   12'd0},    1, '{4'd0,  1'b0, 12'd255, 5'd1}},
      '{0, 0, '{MODE_WRITE,   4'd15, 1'b1, 1'b0, 8'd0,   12'd0},    1, '{4'd0,  1'b0, 12'd255, 5'd1}},
      '{0, 0, '{MODE_REBUILD, 4'd0,  1'b0, 1'b0, 8'd0,   12'd0},    1, '{4'd0,  1'b0, 12'd0,   5'd2}},
      '{0, 0, '{MODE_READ,    4'd0,  1'b0, 1'b0, 8'd0,   12'd0},    1, '{4'd0,  1'b0, 12'd0,   5'd2}},
      // only backups run: first backup alone, then all of them
      '{0, 0, '{MODE_WRITE,   4'd0,  1'b0, 1'b0, 8'd0,   12'd0},    1, '{4'd0,  1'b0, 12'd0,   5'd2}},
      '{0, 0, '{MODE_WRITE,   4'd15, 1'b0, 1'b1, 8'd0,   12'd0},    1, '{4'd0,  1'b0, 12'd0,   5'd2}},
      '{0, 0, '{MODE_WRITE,   4'd3,  1'b1, 1'b1, 8'd3,   12'd0},    1, '{4'd0,  1'b0, 12'd0,   5'd2}},
      '{0, 0, '{MODE_WRITE,   4'd7,  1'b1, 1'b1, 8'd2,   12'd0},    1, '{4'd0,  1'b0, 12'd0,   5'd2}},
      '{0, 0, '{MODE_REBUILD, 4'd0,  1'b0, 1'b0, 8'd0,   12'd0},    1, '{4'd0,  1'b0, 12'd3,   5'd1}},
      '{0, 0, '{MODE_READ,    4'd0,  1'b0, 1'b0, 8'd0,   12'd2},    1, '{4'd3,  1'b1, 12'd3,   5'd1}},
      '{1, 1, '0,                                                   0, '0},
      '{0, 0, '{MODE_REBUILD, 4'd0,  1'b0, 1'b0, 8'd0,   12'd0},    1, '{4'd0,  1'b0, 12'd5,   5'd2}},
      '{0, 0, '{MODE_READ,    4'd0,  1'b0, 1'b0, 8'd0,   12'd1},    0, '0},
      // active servers take over again, out of range read at the top slot
      '{0, 0, '{MODE_WRITE,   4'd5,  1'b1, 1'b0, 8'd255, 12'd0},    1, '{4'd0,  1'b0, 12'd5,   5'd2}},
      '{0, 0, '{MODE_WRITE,   4'd9,  1'b1, 1'b0, 8'd200, 12'd0},    1, '{4'd0,  1'b0, 12'd5,   5'd2}},
      '{0, 0, '{MODE_REBUILD, 4'd0,  1'b0, 1'b0, 8'd0,   12'd0},    1, '{4'd0,  1'b0, 12'd455, 5'd2}},
      '{0, 0, '{MODE_READ,    4'd0,  1'b0, 1'b0, 8'd0,   12'd454},  0, '0},
      '{0, 0, '{MODE_READ,    4'd0,  1'b0, 1'b0, 8'd0,   12'd4095}, 1, '{4'd0,  1'b0, 12'd455, 5'd2}}
   };

   weighted_server_map_builder_unit #(
      .MAX_SERVERS(SERVERS),
      .MAP_DEPTH(MAP_SLOTS),
      .WEIGHT_MAX(255)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_use_all_backup(csr_use_all_backup),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_server_index(req_server_index),
      .req_server_running(req_server_running),
      .req_server_backup(req_server_backup),
      .req_server_weight(req_server_weight),
      .req_slot_index(req_slot_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_slot_server(rsp_slot_server),
      .rsp_slot_valid(rsp_slot_valid),
      .rsp_total_weight(rsp_total_weight),
      .rsp_servers_used(rsp_servers_used)
   );

   always #2 clock = ~clock;

   // Recount eligible servers and refill the slot map by smooth weighted round robin
   function automatic void rebuild_map();
      int act_n, bck_n, act_w, bck_w, first_w, total, used, fill, best, best_v, v;
      bit want_bck, found;
      act_n = 0; bck_n = 0; act_w = 0; bck_w = 0; first_w = 0;
      for (int i = 0; i < SERVERS; i++) begin
         if (run_tbl[i]) begin
            if (bck_tbl[i]) begin
               bck_n++;
               bck_w += int'(wgt_tbl[i]);
               if (bck_n == 1) first_w = int'(wgt_tbl[i]);
            end else begin
               act_n++;
               act_w += int'(wgt_tbl[i]);
            end
         end
      end
      if (act_n > 0) begin
         total = act_w; used = act_n; want_bck = 1'b0;
      end else if (bck_n > 0) begin
         want_bck = 1'b1;
         total = all_backup ? bck_w : first_w;
         used = all_backup ? bck_n : 1;
      end else begin
         total = 0; used = 0; want_bck = 1'b0;
      end
      used_n = used;
      if (used == 0) begin
         map_len = 0;
         return;
      end
      fill = (total > MAP_SLOTS) ? MAP_SLOTS : total;
      map_len = fill;
      for (int i = 0; i < SERVERS; i++) score_tbl[i] = 0;
      for (int o = 0; o < fill; o++) begin
         found = 1'b0; best = 0; best_v = 0;
         for (int i = 0; i < SERVERS; i++) begin
            if (run_tbl[i] && bck_tbl[i] == want_bck && !(used == 1 && found)) begin
               if (used == 1) begin
                  best = i;
                  found = 1'b1;
               end else begin
                  score_tbl[i] += int'(wgt_tbl[i]);
                  v = (score_tbl[i] + total) / total;
                  if (!found || v > best_v) begin
                     best_v = v;
                     best = i;
                     found = 1'b1;
                  end
               end
            end
         end
         slot_tbl[o] = SERVER_W'(best);
         if (used != 1) score_tbl[best] -= total;
      end
   endfunction

   // Apply one request to the shadow state and return its answer
   function automatic map_answer_type map_answer_for(map_request_type r);
      map_answer_type a;
      a = '0;
      case (r.mode)
         MODE_WRITE: begin
            run_tbl[r.server_index] = r.server_running;
            bck_tbl[r.server_index] = r.server_backup;
            wgt_tbl[r.server_index] = r.server_weight;
         end
         MODE_REBUILD: rebuild_map();
         MODE_READ: begin
            if (int'(r.slot_index) < map_len) begin
               a.slot_server = slot_tbl[r.slot_index];
               a.slot_valid = 1'b1;
            end
         end
         default: ;
      endcase
      a.total_weight = TOTAL_W'(map_len);
      a.servers_used = USED_W'(used_n);
      return a;
   endfunction

   function automatic int table_weight_sum();
      int s;
      s = 0;
      for (int i = 0; i < SERVERS; i++) s += int'(wgt_tbl[i]);
      return s;
   endfunction

   function automatic map_request_type random_fields(logic [MODE_W-1:0] mode);
      map_request_type r;
      r.mode = mode;
      r.server_index = INDEX_W'($urandom_range(SERVERS - 1));
      r.server_running = 1'($urandom_range(1));
      r.server_backup = 1'($urandom_range(1));
      r.server_weight = WEIGHT_W'($urandom_range(255));
      r.slot_index = SLOT_W'($urandom_range(MAP_SLOTS - 1));
      return r;
   endfunction

   function automatic map_request_type write_fields(int idx, bit run, bit bck, int w);
      map_request_type r;
      r = random_fields(MODE_WRITE);
      r.server_index = INDEX_W'(idx);
      r.server_running = run;
      r.server_backup = bck;
      r.server_weight = WEIGHT_W'(w);
      return r;
   endfunction

   function automatic map_request_type read_fields(int slot);
      map_request_type r;
      r = random_fields(MODE_READ);
      r.slot_index = SLOT_W'(slot);
      return r;
   endfunction

   // Mostly small weights; keep the table sum bounded so rebuilds stay short
   function automatic int pick_weight(int idx);
      int w;
      w = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(15);
      if (table_weight_sum() - int'(wgt_tbl[idx]) + w > WEIGHT_BUDGET) w = 0;
      return w;
   endfunction

   function automatic void report_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
      end
   endfunction

   // Offer one request, hold it until taken, then record its answer
   task automatic send_request(map_request_type r, bit fixed, map_answer_type want);
      map_answer_type got;
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= r.mode;
      req_server_index <= r.server_index;
      req_server_running <= r.server_running;
      req_server_backup <= r.server_backup;
      req_server_weight <= r.server_weight;
      req_slot_index <= r.slot_index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = map_answer_for(r);
      pending_answers.push_back(fixed ? want : got);
   endtask

   task automatic send_item(map_request_type r);
      send_request(r, 1'b0, '0);
      if (r.mode != MODE_UNUSED) served++;
   endtask

   // Drop valid and wait until every answer is back
   task automatic drain_answers();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_backup_mode(bit value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_use_all_backup <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      all_backup = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Rewrite every entry; a failover leaves only backups running
   task automatic rewrite_table(bit failover);
      bit run, bck;
      for (int i = 0; i < SERVERS; i++) begin
         run = 1'($urandom_range(1));
         bck = failover ? (run | 1'($urandom_range(1))) : ($urandom_range(2) == 0);
         send_item(write_fields(i, run, bck, $urandom_range(15)));
      end
   endtask

   // Writes, a rebuild, then reads; now and then noise or a skipped rebuild
   task automatic run_episode();
      int n;
      int idx;
      if ($urandom_range(99) < 15) begin
         rewrite_table(1'b1);
      end else begin
         n = $urandom_range(5);
         repeat (n) begin
            idx = $urandom_range(SERVERS - 1);
            send_item(write_fields(idx, $urandom_range(9) < 7, $urandom_range(9) < 3,
                                   pick_weight(idx)));
         end
      end
      if ($urandom_range(9) == 0) send_item(random_fields(MODE_UNUSED));
      if ($urandom_range(9) != 0) send_item(random_fields(MODE_REBUILD));
      n = $urandom_range(8, 1);
      repeat (n) begin
         if ($urandom_range(4) == 0) send_item(read_fields($urandom_range(MAP_SLOTS - 1)));
         else send_item(read_fields($urandom_range(map_len + 2)));
      end
   endtask

   // Full table at full weight: longest map, then back to small weights
   task automatic run_heavy_map();
      for (int i = 0; i < SERVERS; i++) send_item(write_fields(i, 1'b1, 1'b0, 255));
      send_item(random_fields(MODE_REBUILD));
      send_item(read_fields(4079));
      send_item(read_fields(4080));
      repeat (4) send_item(read_fields($urandom_range(4079)));
      rewrite_table(1'b0);
   endtask

   // Receiver stall: random, or a long hold when asked
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Compare each taken response with the oldest pending answer
   always @(posedge clock) begin : check_response
      map_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            error_count++;
            $display("%0t: response with no request pending", $realtime);
         end else begin
            want = pending_answers.pop_front();
            report_field("slot_server", 12'(want.slot_server), 12'(rsp_slot_server));
            report_field("slot_valid", 12'(want.slot_valid), 12'(rsp_slot_valid));
            report_field("total_weight", want.total_weight, rsp_total_weight);
            report_field("servers_used", 12'(want.servers_used), 12'(rsp_servers_used));
         end
      end
   end

   initial begin
      #40_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      all_backup = 1'b0;
      map_len = 0;
      used_n = 0;
      for (int i = 0; i < SERVERS; i++) begin
         run_tbl[i] = 1'b0;
         bck_tbl[i] = 1'b0;
         wgt_tbl[i] = '0;
         score_tbl[i] = 0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed requests under the first idling pattern
      send_gap_pct = gap_pct_by_phase[0];
      stall_pct = stall_pct_by_phase[0];
      foreach (probe_tbl[k]) begin
         if (probe_tbl[k].is_csr) begin
            drain_answers();
            write_backup_mode(probe_tbl[k].csr_value);
         end else begin
            send_request(probe_tbl[k].req, probe_tbl[k].fixed, probe_tbl[k].want);
         end
      end

      // Random phases, each with its own idling pattern and backup setting
      for (int p = 0; p < 3; p++) begin
         drain_answers();
         send_gap_pct = gap_pct_by_phase[p];
         stall_pct = stall_pct_by_phase[p];
         write_backup_mode(p == 1);
         rewrite_table(1'b0);
         if (p == 2) begin
            hold_left = HOLD_CYCLES;
            run_heavy_map();
         end
         while (served < (p + 1) * ITEMS_PER_PHASE) run_episode();
      end

      drain_answers();
      repeat (64) @(posedge clock);
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
